// ===== src/lcg_keystream_xor_cipher_assert.svh =====
// Assertion macros used by the checker file.
`ifndef LCG_KEYSTREAM_XOR_CIPHER_ASSERT_SVH
`define LCG_KEYSTREAM_XOR_CIPHER_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while in reset.
`define LCGX_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcgx check failed");

// Next-cycle implication, clocked on clk_i, off while in reset.
`define LCGX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcgx check failed");

`endif

// ===== src/lcgx_pkg.sv =====
// Types and constants of the LCG keystream XOR cipher.
package lcgx_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned IDX_W  = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_SEED = 2'd0,
    REG_MULT = 2'd1,
    REG_INCR = 2'd2,
    REG_MOD  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } lcgx_state_e;

endpackage

// ===== src/lcg_keystream_xor_cipher.sv =====
// LCG keystream XOR cipher: byte stream in, XORed byte stream out.
//
// Every input word is one data byte; it leaves XORed with one byte of a keystream built from
// 64-bit words X0 = seed, X(n+1) = (a*X(n) + c) mod m, least significant byte first. Product
// and sum wrap at 64 bits; m = 0 means no reduction. tuser = 1 on an input word reloads the
// seed and restarts at byte zero; tlast is carried through to the output unchanged. Bytes 0
// to 6 of a keystream word can be taken back to back while the skid word is empty. Byte 7
// also triggers the next-word computation, during which s_axis_tready_o stays low: a
// shift-and-add multiply, then a restoring remainder when m is nonzero, all on one shared
// 65-bit adder. An output register plus a skid word absorb input while the sink stalls; once
// the skid word is full, s_axis_tready_o stays low. Registers (cfg_idx_i): 0 seed,
// 1 multiplier, 2 increment, 3 modulus. A new seed applies at the next start; new a, c, m
// apply from the next word advance that begins after the write.
module lcg_keystream_xor_cipher (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [lcgx_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [lcgx_pkg::WORD_W-1:0]       cfg_wdata_i,
  // input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [lcgx_pkg::BYTE_W-1:0]       s_axis_tdata_i,  // [7:0] data_byte
  input  logic                              s_axis_tuser_i,  // [0] start_of_message
  input  logic                              s_axis_tlast_i,  // end_of_message
  // output stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [lcgx_pkg::BYTE_W-1:0]       m_axis_tdata_o,  // [7:0] out_byte
  output logic                              m_axis_tlast_o   // last
);

  localparam int unsigned W = lcgx_pkg::WORD_W;
  localparam int unsigned B = lcgx_pkg::BYTE_W;

  // configuration registers
  logic [W-1:0] seed_q, mult_q, incr_q, modulus_q;

  // keystream state
  logic [W-1:0]                   cur_word_q, cur_word_d;
  logic [lcgx_pkg::POS_W-1:0]     pos_q, pos_d;

  // sequencer
  lcgx_pkg::lcgx_state_e          state_q, state_d;
  logic [lcgx_pkg::CNT_W-1:0]     cnt_q, cnt_d;

  // iteration datapath: acc doubles as the dividend shifter
  logic [W-1:0] acc_q, acc_d;     // product accumulator, then dividend
  logic [W-1:0] mcand_q, mcand_d; // shifted multiplicand
  logic [W-1:0] mplr_q, mplr_d;   // multiplier bits, LSB first
  logic [W-1:0] modv_q, modv_d;   // modulus latched for this advance
  logic [W-1:0] rem_q, rem_d;     // partial remainder

  // shared adder
  logic [W:0]   add_a, add_b;
  logic         add_cin;
  logic [W+1:0] add_sum;
  logic [W:0]   shifted;

  // output register and skid word
  logic         out_vld_q, sk_vld_q;
  logic [B-1:0] out_dat_q, sk_dat_q;
  logic         out_lst_q, sk_lst_q;

  logic                       s_acc, m_take;
  logic [W-1:0]               word_sel;
  logic [lcgx_pkg::POS_W-1:0] pos_sel;
  logic [B-1:0]               res_byte;

  assign s_axis_tready_o = (state_q == lcgx_pkg::ST_IDLE) && !sk_vld_q;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign m_take          = out_vld_q && m_axis_tready_i;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_dat_q;
  assign m_axis_tlast_o  = out_lst_q;

  // keystream byte for the word being accepted
  assign word_sel = s_axis_tuser_i ? seed_q : cur_word_q;
  assign pos_sel  = s_axis_tuser_i ? '0 : pos_q;
  assign res_byte = s_axis_tdata_i ^ word_sel[{pos_sel, 3'b000} +: B];

  assign shifted  = {rem_q, acc_q[W-1]};
  assign add_sum  = {1'b0, add_a} + {1'b0, add_b} + {{(W+1){1'b0}}, add_cin};

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= '0;
      mult_q    <= {{(W-1){1'b0}}, 1'b1};
      incr_q    <= '0;
      modulus_q <= '0;
    end else if (cfg_we_i) begin
      unique case (lcgx_pkg::cfg_reg_e'(cfg_idx_i))
        lcgx_pkg::REG_SEED: seed_q    <= cfg_wdata_i;
        lcgx_pkg::REG_MULT: mult_q    <= cfg_wdata_i;
        lcgx_pkg::REG_INCR: incr_q    <= cfg_wdata_i;
        lcgx_pkg::REG_MOD:  modulus_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer and keystream next state
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cur_word_d = cur_word_q;
    pos_d      = pos_q;
    acc_d      = acc_q;
    mcand_d    = mcand_q;
    mplr_d     = mplr_q;
    modv_d     = modv_q;
    rem_d      = rem_q;
    add_a      = '0;
    add_b      = '0;
    add_cin    = 1'b0;

    unique case (state_q)
      lcgx_pkg::ST_IDLE: begin
        if (s_acc) begin
          if (pos_sel == lcgx_pkg::POS_W'(7)) begin
            // last byte of the word: start a*X + c, c preloaded in acc
            pos_d   = '0;
            acc_d   = incr_q;
            mcand_d = word_sel;
            mplr_d  = mult_q;
            modv_d  = modulus_q;
            cnt_d   = '0;
            state_d = lcgx_pkg::ST_MUL;
          end else begin
            pos_d      = pos_sel + lcgx_pkg::POS_W'(1);
            cur_word_d = word_sel;
          end
        end
      end

      lcgx_pkg::ST_MUL: begin
        add_a   = {1'b0, acc_q};
        add_b   = {1'b0, mplr_q[0] ? mcand_q : {W{1'b0}}};
        acc_d   = add_sum[W-1:0];
        mcand_d = {mcand_q[W-2:0], 1'b0};
        mplr_d  = {1'b0, mplr_q[W-1:1]};
        cnt_d   = cnt_q + lcgx_pkg::CNT_W'(1);
        if (cnt_q == '1) begin
          cnt_d = '0;
          if (modv_q == '0) begin
            cur_word_d = add_sum[W-1:0];
            state_d    = lcgx_pkg::ST_IDLE;
          end else begin
            rem_d   = '0;
            state_d = lcgx_pkg::ST_DIV;
          end
        end
      end

      lcgx_pkg::ST_DIV: begin
        // restoring remainder step: shifted - m, keep if no borrow (carry out of bit W)
        add_a   = shifted;
        add_b   = ~{1'b0, modv_q};
        add_cin = 1'b1;
        rem_d   = add_sum[W+1] ? add_sum[W-1:0] : shifted[W-1:0];
        acc_d   = {acc_q[W-2:0], 1'b0};
        cnt_d   = cnt_q + lcgx_pkg::CNT_W'(1);
        if (cnt_q == '1) begin
          cnt_d      = '0;
          cur_word_d = rem_d;
          state_d    = lcgx_pkg::ST_IDLE;
        end
      end

      default: state_d = lcgx_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lcgx_pkg::ST_IDLE;
      cnt_q      <= '0;
      cur_word_q <= '0;
      pos_q      <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      cur_word_q <= cur_word_d;
      pos_q      <= pos_d;
    end
  end

  // iteration datapath, no reset needed
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    mplr_q  <= mplr_d;
    modv_q  <= modv_d;
    rem_q   <= rem_d;
  end

  // output register with skid word behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sk_vld_q  <= 1'b0;
    end else begin
      if (s_acc) begin
        if (!out_vld_q || m_take) begin
          out_vld_q <= 1'b1;
        end else begin
          sk_vld_q <= 1'b1;
        end
      end else if (m_take) begin
        out_vld_q <= sk_vld_q;
        sk_vld_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      if (!out_vld_q || m_take) begin
        out_dat_q <= res_byte;
        out_lst_q <= s_axis_tlast_i;
      end else begin
        sk_dat_q <= res_byte;
        sk_lst_q <= s_axis_tlast_i;
      end
    end else if (m_take && sk_vld_q) begin
      out_dat_q <= sk_dat_q;
      out_lst_q <= sk_lst_q;
    end
  end

endmodule

// ===== src/lcgx_checker.sv =====
// Port-level checks for the LCG keystream XOR cipher, bound to the top level.
`include "lcg_keystream_xor_cipher_assert.svh"

module lcgx_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic                        s_axis_tuser_i,
  input logic                        s_axis_tlast_i,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [lcgx_pkg::BYTE_W-1:0] m_axis_tdata_o,
  input logic                        m_axis_tlast_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // stalled output word holds
  `LCGX_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

  // after an accepted word the output register holds a valid word (the new one or an older one)
  `LCGX_ASSERT_NEXT(a_acc_out, s_acc, m_axis_tvalid_o)

  // with the output empty, an accepted word goes straight out with its tlast
  `LCGX_ASSERT_NEXT(a_last_copy, s_acc && !m_axis_tvalid_o,
    m_axis_tlast_o == $past(s_axis_tlast_i))

  // a start byte never advances the word, so the input stays open
  `LCGX_ASSERT_NEXT(a_start_ready, s_acc && s_axis_tuser_i && !m_axis_tvalid_o,
    s_axis_tready_o)

endmodule

bind lcg_keystream_xor_cipher lcgx_checker u_lcgx_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the LCG keystream XOR cipher.
module testbench;

  localparam int unsigned SETTLE_CYCLES = 300;   // longer than one next-word computation
  localparam int unsigned HOLD_CYCLES   = 400;   // long sink stall to back up the block
  localparam int unsigned STALL_LIMIT   = 6000;  // cycles without any word moving
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_BYTES   = 72;

  localparam logic [lcgx_pkg::WORD_W-1:0] LCG_A = 64'd6364136223846793005;
  localparam logic [lcgx_pkg::WORD_W-1:0] LCG_C = 64'd1442695040888963407;

  typedef struct packed {
    logic [lcgx_pkg::BYTE_W-1:0] data;
    logic                        last;
  } cipher_word_t;

  // Predicts the cipher output and checks the output stream in order.
  class keystream_scoreboard;
    logic [lcgx_pkg::WORD_W-1:0] seed_r, mult_r, incr_r, mod_r;
    logic [lcgx_pkg::WORD_W-1:0] key_word;
    logic [lcgx_pkg::POS_W-1:0]  key_pos;
    cipher_word_t                pending_q[$];
    int                          errors;
    int                          checked;

    function new();
      seed_r   = '0;
      mult_r   = 64'd1;
      incr_r   = '0;
      mod_r    = '0;
      key_word = '0;
      key_pos  = '0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void set_reg(lcgx_pkg::cfg_reg_e idx, logic [lcgx_pkg::WORD_W-1:0] val);
      case (idx)
        lcgx_pkg::REG_SEED: seed_r = val;
        lcgx_pkg::REG_MULT: mult_r = val;
        lcgx_pkg::REG_INCR: incr_r = val;
        lcgx_pkg::REG_MOD:  mod_r  = val;
        default: ;
      endcase
    endfunction

    // X(n+1) = (a*X(n) + c) mod m, both wrapping at 64 bits
    function logic [lcgx_pkg::WORD_W-1:0] next_key_word(logic [lcgx_pkg::WORD_W-1:0] x);
      logic [lcgx_pkg::WORD_W-1:0] y;
      y = mult_r * x + incr_r;
      if (mod_r != '0) y = y % mod_r;
      return y;
    endfunction

    function void note_input(logic [lcgx_pkg::BYTE_W-1:0] data, logic sop, logic eop);
      cipher_word_t w;
      if (sop) begin
        key_word = seed_r;
        key_pos  = '0;
      end
      w.data = data ^ key_word[{key_pos, 3'b000} +: lcgx_pkg::BYTE_W];
      w.last = eop;
      pending_q.push_back(w);
      if (key_pos == 3'd7) key_word = next_key_word(key_word);
      key_pos = key_pos + 3'd1;   // wraps 7 -> 0
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic [lcgx_pkg::BYTE_W-1:0] data, logic last);
      cipher_word_t w;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected output word data=%02h last=%0b", data, last));
      end else begin
        w = pending_q.pop_front();
        checked++;
        if (data !== w.data)
          report($sformatf("word %0d data %02h, want %02h", checked, data, w.data));
        if (last !== w.last)
          report($sformatf("word %0d last %0b, want %0b", checked, last, w.last));
      end
    endtask

    task check_leftover();
      while (pending_q.size() != 0) begin
        void'(pending_q.pop_front());
        report("expected output word never arrived");
      end
    endtask
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [lcgx_pkg::IDX_W-1:0]    cfg_idx_i;
  logic [lcgx_pkg::WORD_W-1:0]   cfg_wdata_i;
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  logic [lcgx_pkg::BYTE_W-1:0]   s_axis_tdata_i;   // [7:0] data_byte
  logic                          s_axis_tuser_i;   // [0] start_of_message
  logic                          s_axis_tlast_i;   // end_of_message
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  logic [lcgx_pkg::BYTE_W-1:0]   m_axis_tdata_o;   // [7:0] out_byte
  logic                          m_axis_tlast_o;   // last

  keystream_scoreboard sb;
  bit                  tx_burst;         // sender never idles
  bit                  rx_burst;         // sink never stalls
  bit                  hold_req;         // ask the sink for one long stall
  int                  quiet_cycles;
  int                  bytes_sent;
  int                  msgs_sent;
  int                  cfg_writes;

  lcg_keystream_xor_cipher u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [lcgx_pkg::WORD_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 64'd1;
      2:       return '1;
      3:       return 64'($urandom_range(2, 1000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Sample both streams and config writes at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        sb.set_reg(lcgx_pkg::cfg_reg_e'(cfg_idx_i), cfg_wdata_i);
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        sb.note_input(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
      end
      if (cfg_we_i || (s_axis_tvalid_i && s_axis_tready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Sink: random stalls, bursts without stalls, one long hold on request.
  initial begin
    int stall_left;
    int n;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        stall_left = HOLD_CYCLES - 1;
      end else begin
        n = rx_burst ? 0 : idle_len();
        if (n > 0) begin
          m_axis_tready_i <= 1'b0;
          stall_left = n - 1;
        end else begin
          m_axis_tready_i <= 1'b1;
        end
      end
    end
  end

  task automatic send_byte(input logic [lcgx_pkg::BYTE_W-1:0] data, input logic sop,
                           input logic eop);
    int gap;
    gap = tx_burst ? 0 : idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= sop;
    s_axis_tlast_i  <= eop;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
    if (sop) msgs_sent++;
  endtask

  // well-formed message: start on the first byte, end on the last
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom), i == 0, i == len - 1);
  endtask

  // stray flags anywhere, including end without start and repeated starts
  task automatic send_noise(input int len);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endtask

  // Let everything drain, then give the keystream engine time to finish its word.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input lcgx_pkg::cfg_reg_e idx,
                           input logic [lcgx_pkg::WORD_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_writes++;
  endtask

  task automatic load_config(input logic [lcgx_pkg::WORD_W-1:0] seed,
                             input logic [lcgx_pkg::WORD_W-1:0] mult,
                             input logic [lcgx_pkg::WORD_W-1:0] incr,
                             input logic [lcgx_pkg::WORD_W-1:0] modv);
    write_reg(lcgx_pkg::REG_SEED, seed);
    write_reg(lcgx_pkg::REG_MULT, mult);
    write_reg(lcgx_pkg::REG_INCR, incr);
    write_reg(lcgx_pkg::REG_MOD,  modv);
  endtask

  initial begin
    int left;
    int len;
    sb              = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = lcgx_pkg::REG_SEED;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    tx_burst        = 1'b0;
    rx_burst        = 1'b0;
    hold_req        = 1'b0;
    quiet_cycles    = 0;
    bytes_sent      = 0;
    msgs_sent       = 0;
    cfg_writes      = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // bytes before any start: keystream runs from the reset state
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b0);
    wait_idle();

    load_config({$urandom, $urandom}, LCG_A, LCG_C, '0);
    send_byte(8'hFF, 1'b1, 1'b1);              // one-byte message
    for (int i = 0; i < 17; i++)               // crosses two word advances
      send_byte(i[0] ? 8'hFF : 8'h00, i == 0, i == 16);
    send_byte(8'h5A, 1'b0, 1'b0);              // keystream keeps going after end
    send_byte(8'hC3, 1'b0, 1'b1);
    send_byte(8'h81, 1'b0, 1'b0);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      // first phases pin the extremes, the rest draw from them at random
      case (ph)
        0:       load_config('1, '1, '1, '1);
        1:       load_config('0, '0, {$urandom, $urandom}, '0);
        2:       load_config({$urandom, $urandom}, LCG_A, LCG_C, 64'd1);
        3:       load_config({$urandom, $urandom}, LCG_A, '0, {$urandom, $urandom});
        default: load_config(pick_value(), pick_value(), pick_value(), pick_value());
      endcase
      tx_burst = (ph == 1) || ($urandom_range(0, 3) == 0);
      rx_burst = (ph != 1) && ($urandom_range(0, 3) == 0);
      if (ph == 1) hold_req = 1'b1;   // sink backs up while the sender keeps pushing

      left = PHASE_BYTES;
      // from phase 1 on the head is noise with random flags: a message may span the register change
      if (ph > 0) begin
        send_noise(3);
        left -= 3;
      end
      while (left > 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 30);
        if (len > left) len = left;
        if ($urandom_range(0, 9) < 8) send_message(len);
        else send_noise(len);
        left -= len;
      end
      wait_idle();
    end

    sb.check_leftover();
    $display("Run covered %0d bytes in %0d messages, %0d register writes, %0d config phases",
             bytes_sent, msgs_sent, cfg_writes, RAND_PHASES + 2);
    $display("Checked %0d output words, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
